// ===== hw/rtl/dust_sensor_frame_receiver_macros.svh =====
// Assertion macros for the dust sensor frame receiver.
// Used by the parser and the output buffer; no other dependencies.
`ifndef DUST_SENSOR_FRAME_RECEIVER_MACROS_SVH
`define DUST_SENSOR_FRAME_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define DSFR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define DSFR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSFR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define DSFR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dsfr_pkg.sv =====
// Shared types and constants of the dust sensor frame receiver.
// No dependencies; imported by every module of the block.
package dsfr_pkg;

    // Frame layout
    localparam int FRAME_BYTES   = 10;
    localparam int POS_W         = $clog2(FRAME_BYTES + 1);
    localparam int PAYLOAD_BYTES = 6;

    localparam logic [POS_W-1:0] IDX_HEAD  = POS_W'(0);
    localparam logic [POS_W-1:0] IDX_CMD   = POS_W'(1);
    localparam logic [POS_W-1:0] IDX_DATA1 = POS_W'(2);
    localparam logic [POS_W-1:0] IDX_CSUM  = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] IDX_TAIL  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_HELD  = POS_W'(FRAME_BYTES);

    // Result status codes
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_MEASURE  = 3'd1,
        ST_HELD     = 3'd2,
        ST_CSUM_ERR = 3'd3,
        ST_TAIL_ERR = 3'd4
    } status_t;

    // Input operation codes
    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_REPORT_MODE = 2'd0,
        REG_HEAD_BYTE   = 2'd1,
        REG_TAIL_BYTE   = 2'd2,
        REG_MEASURE_CMD = 2'd3
    } reg_idx_t;

    localparam logic [7:0] HEAD_BYTE_RST   = 8'd170;
    localparam logic [7:0] TAIL_BYTE_RST   = 8'd171;
    localparam logic [7:0] MEASURE_CMD_RST = 8'd192;

    // Configuration handed from the register bank to the parser
    typedef struct packed {
        logic       report_mode;
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] measure_cmd_id;
    } cfg_t;

    // One result word
    typedef struct packed {
        status_t    status;
        logic [7:0] frame_cmd_id;
        logic [7:0] data_byte_1;
        logic [7:0] data_byte_2;
        logic [7:0] data_byte_3;
        logic [7:0] data_byte_4;
        logic [7:0] data_byte_5;
        logic [7:0] data_byte_6;
    } result_t;

endpackage

// ===== hw/rtl/dsfr_cfg_regs.sv =====
// Configuration register bank of the dust sensor frame receiver.
// Depends on dsfr_pkg for the register indexes and the cfg_t struct.
module dsfr_cfg_regs
    import dsfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_mode    <= 1'b0;
            cfg_reg.head_byte      <= HEAD_BYTE_RST;
            cfg_reg.tail_byte      <= TAIL_BYTE_RST;
            cfg_reg.measure_cmd_id <= MEASURE_CMD_RST;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_REPORT_MODE: cfg_reg.report_mode    <= cfg_data[0];
                REG_HEAD_BYTE:   cfg_reg.head_byte      <= cfg_data;
                REG_TAIL_BYTE:   cfg_reg.tail_byte      <= cfg_data;
                REG_MEASURE_CMD: cfg_reg.measure_cmd_id <= cfg_data;
                default:         cfg_reg.report_mode    <= cfg_reg.report_mode;
            endcase
        end
    end

endmodule

// ===== hw/rtl/dsfr_parser.sv =====
// Frame parser: byte position, running checksum, frame store and result logic.
// Depends on dsfr_pkg and on the assertion macros header.
`include "dust_sensor_frame_receiver_macros.svh"
module dsfr_parser
    import dsfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_accept,
    input  logic       op,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       store_reg [FRAME_BYTES];
    logic             store_we;
    status_t          status;

    // Position, checksum and completion checks for the incoming word
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        store_we = 1'b0;
        status   = ST_NONE;
        if (op_t'(op) == OP_RELEASE)
        begin
            pos_next = '0;
            sum_next = '0;
        end
        else if (pos_reg >= POS_HELD)
        begin
            pos_next = pos_reg;
        end
        else if (pos_reg == IDX_HEAD && rx_byte != cfg.head_byte)
        begin
            pos_next = pos_reg;
        end
        else
        begin
            store_we = 1'b1;
            if (pos_reg >= IDX_DATA1 && pos_reg < IDX_CSUM)
            begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg != IDX_TAIL)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                // Last byte: the tail byte is the incoming one
                sum_next = '0;
                if (store_reg[IDX_HEAD] != cfg.head_byte || rx_byte != cfg.tail_byte)
                begin
                    status   = ST_TAIL_ERR;
                    pos_next = '0;
                end
                else if (store_reg[IDX_CSUM] != sum_reg)
                begin
                    status   = ST_CSUM_ERR;
                    pos_next = '0;
                end
                else if (cfg.report_mode && store_reg[IDX_CMD] == cfg.measure_cmd_id)
                begin
                    status   = ST_MEASURE;
                    pos_next = '0;
                end
                else
                begin
                    status   = ST_HELD;
                    pos_next = POS_HELD;
                end
            end
        end
    end

    // Result word: frame bytes only when a frame completed
    always_comb
    begin
        result = '0;
        result.status = status;
        if (status != ST_NONE)
        begin
            result.frame_cmd_id = store_reg[IDX_CMD];
            result.data_byte_1  = store_reg[IDX_DATA1];
            result.data_byte_2  = store_reg[IDX_DATA1 + POS_W'(1)];
            result.data_byte_3  = store_reg[IDX_DATA1 + POS_W'(2)];
            result.data_byte_4  = store_reg[IDX_DATA1 + POS_W'(3)];
            result.data_byte_5  = store_reg[IDX_DATA1 + POS_W'(4)];
            result.data_byte_6  = store_reg[IDX_DATA1 + POS_W'(5)];
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (in_accept)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Frame store keeps every byte of the current frame
    always_ff @(posedge clk)
    begin
        if (in_accept && store_we)
        begin
            store_reg[pos_reg] <= rx_byte;
        end
    end

    `DSFR_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos_reg <= POS_HELD,
        "byte position beyond the held slot")
    `DSFR_ASSERT_NXT(a_release_clears, clk, rst_n, in_accept && op_t'(op) == OP_RELEASE,
        pos_reg == '0 && sum_reg == '0, "release did not clear the parser")
    `DSFR_ASSERT_NXT(a_done_restarts, clk, rst_n, in_accept && status != ST_NONE,
        (pos_reg == '0 || pos_reg == POS_HELD) && sum_reg == '0,
        "completed frame left the parser mid-frame")

endmodule

// ===== hw/rtl/dsfr_out_buf.sv =====
// Output register with a skid stage for the result words.
// Depends on dsfr_pkg for result_t and on the assertion macros header.
`include "dust_sensor_frame_receiver_macros.svh"
module dsfr_out_buf
    import dsfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push && (!out_valid_reg || pop))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push && (!out_valid_reg || pop))
        begin
            out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    `DSFR_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid word present without an output word")
    `DSFR_ASSERT_IMP(a_skid_fill, clk, rst_n, $rose(skid_valid_reg),
        $past(out_valid_reg) && !$past(out_ready) && $past(push),
        "skid stage filled without a stalled output")
    `DSFR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_data_reg),
        "stalled output word changed or vanished")

endmodule

// ===== hw/rtl/dust_sensor_frame_receiver.sv =====
// Top level of the dust sensor frame receiver.
// Depends on dsfr_pkg, dsfr_cfg_regs, dsfr_parser and dsfr_out_buf.
//
//  Channel   Direction  Handshake                Payload
//  s_axis    in         s_tvalid / s_tready      s_tdata: rx_byte; s_tuser: op
//  m_axis    out        m_tvalid / m_tready      m_tdata: frame bytes, readings;
//                                                m_tuser: status
//  cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each accepted word yields a registered result word, one per cycle while s_tready is high.
// The parser updates its position, checksum and store in the cycle of acceptance.
// A skid stage behind the result register takes one word while the
// output is stalled; s_tready drops only when both stages hold a word.
// Reset clears the parser position and the checksum and returns the
// configuration to its default values.
module dust_sensor_frame_receiver
    import dsfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] op
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] frame_cmd_id, [15:8]..[55:48] data_byte_1..6,
                                   // [71:56] fine_particles, [87:72] coarse_particles
    output logic [2:0]  m_tuser,   // [2:0] status
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg;
    result_t result;
    result_t out_word;
    logic    in_accept;

    assign in_accept = s_tvalid && s_tready;

    dsfr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_accept (in_accept),
        .op        (s_tuser),
        .rx_byte   (s_tdata),
        .result    (result)
    );

    dsfr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_data  (result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_word)
    );

    // Pack the result word; the readings are little-endian byte pairs
    assign m_tuser = 3'(out_word.status);
    assign m_tdata = {out_word.data_byte_4, out_word.data_byte_3,
                      out_word.data_byte_2, out_word.data_byte_1,
                      out_word.data_byte_6, out_word.data_byte_5,
                      out_word.data_byte_4, out_word.data_byte_3,
                      out_word.data_byte_2, out_word.data_byte_1,
                      out_word.frame_cmd_id};

endmodule
